FILE: rtl/lcp2_pkg.sv
package lcp2_pkg;

    // Largest modulus exponent handled by the datapath
    localparam int WIDTH   = 64;
    // Bit position index and position counter widths
    localparam int IDX_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int CNT_W   = $clog2(WIDTH + 1);
    // Fixed port widths
    localparam int FIELD_W = 64;
    localparam int SIZE_W  = 7;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SKIP   = 4'b0010,
        ST_SOLVE  = 4'b0100,
        ST_FINISH = 4'b1000
    } lcp2_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic skip_step;
        logic solve_step;
        logic set_fail;
        logic publish;
    } lcp2_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pos_lt_n;
        logic a_bit;
        logic b_bit;
    } lcp2_status_t;

endpackage

FILE: rtl/linear_congruence_pow2_solver.sv
// Solves multiplier * factor = target_value mod 2^n, one bit position per cycle.
// Trailing zero positions of the multiplier are skipped first, which can end the item
// early; each remaining bit position below n (n = saturated mod_bits) is walked once
// by the single add-and-compare step.
// A new input is taken once the previous item is published to the output register,
// while that result still waits there.
// Reset: rst_n asynchronous, active low; clears the controller and all registers.
module linear_congruence_pow2_solver (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [lcp2_pkg::FIELD_W-1:0]          multiplier,
    input  logic [lcp2_pkg::FIELD_W-1:0]          target_value,
    input  logic [lcp2_pkg::SIZE_W-1:0]           mod_bits,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lcp2_pkg::FIELD_W-1:0]          factor,
    output logic                                  no_solution
);

    lcp2_pkg::lcp2_cmd_t    cmd;
    lcp2_pkg::lcp2_status_t status;

    lcp2_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lcp2_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .multiplier     (multiplier),
        .target_value   (target_value),
        .mod_bits       (mod_bits),
        .factor         (factor),
        .no_solution    (no_solution)
    );

endmodule

FILE: rtl/lcp2_datapath.sv
module lcp2_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lcp2_pkg::lcp2_cmd_t       cmd,
    output lcp2_pkg::lcp2_status_t    status,
    input  logic [lcp2_pkg::FIELD_W-1:0] multiplier,
    input  logic [lcp2_pkg::FIELD_W-1:0] target_value,
    input  logic [lcp2_pkg::SIZE_W-1:0]  mod_bits,
    output logic [lcp2_pkg::FIELD_W-1:0] factor,
    output logic                      no_solution
);

    logic [lcp2_pkg::WIDTH-1:0] a_reg,      a_next;
    logic [lcp2_pkg::WIDTH-1:0] b_reg,      b_next;
    logic [lcp2_pkg::WIDTH-1:0] a_sh_reg,   a_sh_next;
    logic [lcp2_pkg::WIDTH-1:0] onehot_reg, onehot_next;
    logic [lcp2_pkg::WIDTH-1:0] sum_reg,    sum_next;
    logic [lcp2_pkg::WIDTH-1:0] x_reg,      x_next;
    logic [lcp2_pkg::CNT_W-1:0] pos_reg,    pos_next;
    logic [lcp2_pkg::CNT_W-1:0] n_reg,      n_next;
    logic                       fail_reg,   fail_next;
    logic [lcp2_pkg::WIDTH-1:0] factor_reg, factor_next;
    logic                       nosol_reg,  nosol_next;
    logic [lcp2_pkg::IDX_W-1:0] pos_idx;
    logic                       sum_bit;
    logic [lcp2_pkg::CNT_W-1:0] n_sat;

    // Bit selection at the current position
    assign pos_idx         = pos_reg[lcp2_pkg::IDX_W-1:0];
    assign sum_bit         = sum_reg[pos_idx];
    assign status.pos_lt_n = (pos_reg < n_reg);
    assign status.a_bit    = a_reg[pos_idx];
    assign status.b_bit    = b_reg[pos_idx];

    // Saturate the modulus exponent to the datapath width
    assign n_sat = (mod_bits > lcp2_pkg::SIZE_W'(lcp2_pkg::WIDTH))
                   ? lcp2_pkg::CNT_W'(lcp2_pkg::WIDTH)
                   : mod_bits[lcp2_pkg::CNT_W-1:0];

    // Next-state logic for the working registers
    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        a_sh_next   = a_sh_reg;
        onehot_next = onehot_reg;
        sum_next    = sum_reg;
        x_next      = x_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        fail_next   = fail_reg;
        factor_next = factor_reg;
        nosol_next  = nosol_reg;
        if (cmd.load)
        begin
            a_next      = multiplier[lcp2_pkg::WIDTH-1:0];
            b_next      = target_value[lcp2_pkg::WIDTH-1:0];
            a_sh_next   = multiplier[lcp2_pkg::WIDTH-1:0];
            onehot_next = lcp2_pkg::WIDTH'(1);
            sum_next    = '0;
            x_next      = '0;
            pos_next    = '0;
            n_next      = n_sat;
            fail_next   = 1'b0;
        end
        // Advance past a trailing zero of the multiplier
        if (cmd.skip_step)
        begin
            pos_next = pos_reg + lcp2_pkg::CNT_W'(1);
        end
        // Resolve one factor bit and fold the shifted multiplier into the sum
        if (cmd.solve_step)
        begin
            if (status.b_bit != sum_bit)
            begin
                x_next   = x_reg | onehot_reg;
                sum_next = sum_reg + a_sh_reg;
            end
            pos_next    = pos_reg + lcp2_pkg::CNT_W'(1);
            a_sh_next   = a_sh_reg << 1;
            onehot_next = onehot_reg << 1;
        end
        if (cmd.set_fail)
        begin
            fail_next = 1'b1;
        end
        // Move the finished result into the output register
        if (cmd.publish)
        begin
            factor_next = fail_reg ? '0 : x_reg;
            nosol_next  = fail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg      <= '0;
            b_reg      <= '0;
            a_sh_reg   <= '0;
            onehot_reg <= '0;
            sum_reg    <= '0;
            x_reg      <= '0;
            pos_reg    <= '0;
            n_reg      <= '0;
            fail_reg   <= 1'b0;
            factor_reg <= '0;
            nosol_reg  <= 1'b0;
        end
        else
        begin
            a_reg      <= a_next;
            b_reg      <= b_next;
            a_sh_reg   <= a_sh_next;
            onehot_reg <= onehot_next;
            sum_reg    <= sum_next;
            x_reg      <= x_next;
            pos_reg    <= pos_next;
            n_reg      <= n_next;
            fail_reg   <= fail_next;
            factor_reg <= factor_next;
            nosol_reg  <= nosol_next;
        end
    end

    assign factor      = lcp2_pkg::FIELD_W'(factor_reg);
    assign no_solution = nosol_reg;

`ifndef ASSERT_OFF
    // Running sum agrees with the target on every position already walked
    a_sum_matches: assert property (@(posedge clk) disable iff (!rst_n)
        !fail_reg |-> (((sum_reg ^ b_reg)
            & ((lcp2_pkg::WIDTH'(1) << pos_reg) - lcp2_pkg::WIDTH'(1))) == '0))
        else $error("running sum disagrees with target below position");

    // Each step moves the position by exactly one
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.solve_step || cmd.skip_step) && !cmd.load
            |=> pos_reg == $past(pos_reg) + lcp2_pkg::CNT_W'(1))
        else $error("position did not advance by one");

    // A failed item publishes a zero factor with the flag set
    a_fail_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish && fail_reg |=> factor_reg == '0 && nosol_reg)
        else $error("failed item published a nonzero factor");
`endif

endmodule

FILE: rtl/lcp2_ctrl.sv
module lcp2_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  lcp2_pkg::lcp2_status_t status,
    output lcp2_pkg::lcp2_cmd_t    cmd
);

    lcp2_pkg::lcp2_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  slot_free;

    // Output register can take a result when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == lcp2_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            lcp2_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lcp2_pkg::ST_SKIP;
                end
            end
            // Walk the trailing zeros of the multiplier
            lcp2_pkg::ST_SKIP:
            begin
                if (!status.pos_lt_n)
                begin
                    state_next = lcp2_pkg::ST_FINISH;
                end
                else if (status.a_bit)
                begin
                    state_next = lcp2_pkg::ST_SOLVE;
                end
                else if (status.b_bit)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = lcp2_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.skip_step = 1'b1;
                end
            end
            // One factor bit per cycle up to the modulus exponent
            lcp2_pkg::ST_SOLVE:
            begin
                if (!status.pos_lt_n)
                begin
                    state_next = lcp2_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.solve_step = 1'b1;
                end
            end
            // Hand the result to the output register once it has room
            lcp2_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lcp2_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcp2_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcp2_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // A publish always fills the output register
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("published result not presented");

    // Accepting a transaction closes the input until the item finishes
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input reopened right after accept");

    // Never publish over a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> slot_free)
        else $error("result overwritten before it was taken");
`endif

endmodule

FILE: tb/sv/linear_congruence_pow2_solver_tb.sv
module linear_congruence_pow2_solver_tb;

    // One expected solver result
    typedef struct packed {
        logic [lcp2_pkg::FIELD_W-1:0] factor;
        logic                         no_solution;
    } solution_t;

    // One directed stimulus row; the fixed result is used only when use_fixed is set
    typedef struct packed {
        logic [lcp2_pkg::FIELD_W-1:0] a;
        logic [lcp2_pkg::FIELD_W-1:0] b;
        logic [lcp2_pkg::SIZE_W-1:0]  n;
        logic                         use_fixed;
        logic [lcp2_pkg::FIELD_W-1:0] fix_factor;
        logic                         fix_nosol;
    } vector_t;

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MSB  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALT1 = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [63:0] ALT0 = 64'h5555_5555_5555_5555;
    localparam int NUM_DIRECTED  = 23;
    localparam int NUM_RANDOM    = 1700;

    localparam vector_t DIRECTED [NUM_DIRECTED] = '{
        // zero multiplier, zero target
        '{64'd0, 64'd0, 7'd64, 1'b1, 64'd0, 1'b0},
        // zero multiplier, nonzero target
        '{64'd0, 64'd1, 7'd64, 1'b1, 64'd0, 1'b1},
        // target set only above the modulus
        '{64'd0, 64'h100, 7'd8, 1'b1, 64'd0, 1'b0},
        // modulus of one
        '{64'h1234_5678_9ABC_DEF1, ONES, 7'd0, 1'b1, 64'd0, 1'b0},
        // largest bit size saturates
        '{64'd1, ONES, 7'd127, 1'b1, ONES, 1'b0},
        '{64'd1, ONES, 7'd64, 1'b1, ONES, 1'b0},
        // inverse of minus one is minus one
        '{ONES, 64'd1, 7'd64, 1'b1, ONES, 1'b0},
        // even multiplier, odd target
        '{64'd2, 64'd1, 7'd64, 1'b1, 64'd0, 1'b1},
        // all trailing zeros but the top bit
        '{MSB, MSB, 7'd64, 1'b1, 64'd1, 1'b0},
        '{MSB, 64'd0, 7'd64, 1'b1, 64'd0, 1'b0},
        '{MSB, 64'h4000_0000_0000_0000, 7'd64, 1'b1, 64'd0, 1'b1},
        // multiplier vanishes modulo 2^n
        '{MSB, 64'd1, 7'd63, 1'b1, 64'd0, 1'b1},
        '{64'd4, 64'd8, 7'd3, 1'b1, 64'd0, 1'b0},
        '{64'd1, 64'd1, 7'd1, 1'b1, 64'd1, 1'b0},
        '{64'd3, 64'd1, 7'd65, 1'b0, 64'd0, 1'b0},
        '{64'd3, 64'h0F1E_2D3C_4B5A_6978, 7'd64, 1'b0, 64'd0, 1'b0},
        '{ALT1, ALT0, 7'd64, 1'b1, 64'd0, 1'b1},
        '{ALT0, ALT1, 7'd64, 1'b0, 64'd0, 1'b0},
        '{ONES, 64'd0, 7'd64, 1'b1, 64'd0, 1'b0},
        '{64'd6, 64'd4, 7'd7, 1'b0, 64'd0, 1'b0},
        '{64'd0, 64'd0, 7'd100, 1'b1, 64'd0, 1'b0},
        '{64'd3, 64'd3, 7'd2, 1'b1, 64'd1, 1'b0},
        '{ONES, ONES, 7'd127, 1'b1, 64'd1, 1'b0}
    };

    logic                         clk;
    logic                         rst_n        = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         in_ready;
    logic [lcp2_pkg::FIELD_W-1:0] multiplier   = '0;
    logic [lcp2_pkg::FIELD_W-1:0] target_value = '0;
    logic [lcp2_pkg::SIZE_W-1:0]  mod_bits     = '0;
    logic                         out_valid;
    logic                         out_ready    = 1'b0;
    logic [lcp2_pkg::FIELD_W-1:0] factor;
    logic                         no_solution;

    solution_t pending_solutions [$];
    int        error_count     = 0;
    int        items_sent      = 0;
    int        results_checked = 0;
    int        unsolvable_seen = 0;
    int        saturated_sizes = 0;
    bit        calm_phase      = 1'b0;

    linear_congruence_pow2_solver u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .multiplier     (multiplier),
        .target_value   (target_value),
        .mod_bits       (mod_bits),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .factor         (factor),
        .no_solution    (no_solution)
    );

    // Solve a * x = b mod 2^n bit by bit, skipping trailing zeros of a first
    function automatic solution_t predict_solution(logic [63:0] a, logic [63:0] b,
                                                   logic [lcp2_pkg::SIZE_W-1:0] size);
        int unsigned n;
        int unsigned t;
        int unsigned i;
        int unsigned pos;
        logic [63:0] sum;
        logic [63:0] x;
        logic        fail;
        solution_t   res;
        n    = size;
        t    = 0;
        sum  = '0;
        x    = '0;
        fail = 1'b0;
        if (n > lcp2_pkg::WIDTH)
            n = lcp2_pkg::WIDTH;
        if (n < 64)
            b = b & ((64'd1 << n) - 64'd1);
        // skip trailing zeros, bound tested ahead of the bit
        while (t < n) begin
            if (a[t])
                break;
            if (b[t]) begin
                fail = 1'b1;
                break;
            end
            t++;
        end
        if (!fail) begin
            for (i = 0; i + t < n; i++) begin
                pos = i + t;
                if (b[pos] != sum[pos]) begin
                    x[i] = 1'b1;
                    sum  = sum + (a << i);
                end
            end
        end
        res.factor      = fail ? 64'd0 : x;
        res.no_solution = fail;
        return res;
    endfunction

    // Offer one transaction, hold it until accepted, then record its expected result
    task automatic send_item(logic [63:0] a, logic [63:0] b,
                             logic [lcp2_pkg::SIZE_W-1:0] n,
                             logic use_fixed, solution_t fixed_res);
        while (!calm_phase && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        multiplier   <= a;
        target_value <= b;
        mod_bits     <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_solutions.push_back(use_fixed ? fixed_res : predict_solution(a, b, n));
        items_sent++;
        if (n > lcp2_pkg::WIDTH)
            saturated_sizes++;
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, a quiet stretch, and one long hold-off to back up the block
    initial begin
        bit held_off;
        held_off = 1'b0;
        forever begin
            @(posedge clk);
            if (!held_off && items_sent >= 400) begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (500) @(posedge clk);
            end else begin
                out_ready <= calm_phase || ($urandom_range(99) >= 24);
            end
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk) begin
        solution_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_solutions.size() == 0) begin
                $error("unexpected result: factor=%h no_solution=%b", factor, no_solution);
                error_count++;
            end else begin
                want = pending_solutions.pop_front();
                results_checked++;
                if (no_solution)
                    unsolvable_seen++;
                if (factor !== want.factor) begin
                    $error("factor mismatch: expected %h, actual %h", want.factor, factor);
                    error_count++;
                end
                if (no_solution !== want.no_solution) begin
                    $error("no_solution mismatch: expected %b, actual %b",
                           want.no_solution, no_solution);
                    error_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then random items
    initial begin
        int          k;
        int unsigned tz;
        int unsigned pick;
        int unsigned eff;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] x;
        logic [63:0] mask;
        logic [lcp2_pkg::SIZE_W-1:0] n;
        solution_t   fixed_res;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (k = 0; k < NUM_DIRECTED; k++) begin
            fixed_res.factor      = DIRECTED[k].fix_factor;
            fixed_res.no_solution = DIRECTED[k].fix_nosol;
            send_item(DIRECTED[k].a, DIRECTED[k].b, DIRECTED[k].n,
                      DIRECTED[k].use_fixed, fixed_res);
        end

        // random items, mostly solvable congruences built from a chosen factor
        fixed_res = '0;
        for (k = 0; k < NUM_RANDOM; k++) begin
            calm_phase = (k >= 1000 && k < 1300);
            pick = $urandom_range(99);
            if (pick < 5)
                n = 7'd0;
            else if (pick < 13)
                n = 7'($urandom_range(127, 65));
            else
                n = 7'($urandom_range(64, 1));
            eff  = (n > lcp2_pkg::WIDTH) ? lcp2_pkg::WIDTH : n;
            mask = (eff >= 64) ? ONES : ((64'd1 << eff) - 64'd1);

            // multiplier with a chosen number of trailing zeros
            tz = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
            pick = $urandom_range(99);
            if (pick < 3)
                a = '0;
            else if (pick < 10)
                a = {$urandom, $urandom};
            else
                a = ({$urandom, $urandom} | 64'd1) << tz;

            // target: a real product with noise above the modulus, or random
            x = {$urandom, $urandom};
            if ($urandom_range(99) < 65)
                b = ((a * x) & mask) | ({$urandom, $urandom} & ~mask);
            else
                b = {$urandom, $urandom};
            send_item(a, b, n, 1'b0, fixed_res);
        end
        calm_phase = 1'b0;
        in_valid <= 1'b0;

        // drain, then allow the block to settle
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Solved %0d transactions (%0d directed), %0d without solution,",
                 results_checked, NUM_DIRECTED, unsolvable_seen);
        $display("%0d with an oversized modulus exponent, under random and held back-pressure.",
                 saturated_sizes);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Timeout
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lcp2_pkg.sv
rtl/lcp2_datapath.sv
rtl/lcp2_ctrl.sv
rtl/linear_congruence_pow2_solver.sv
tb/sv/linear_congruence_pow2_solver_tb.sv
